// File: sv/ioc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the interval overlap counter.
// No dependencies; used by ioc_search and interval_overlap_counter_core.
package ioc_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int COORD_W     = 32;
    localparam int CFG_W       = 11;
    localparam int OUT_COUNT_W = 11;
    localparam int TOTAL_W     = 32;

    // request modes
    localparam logic [1:0] MODE_WR_START = 2'd0;
    localparam logic [1:0] MODE_WR_END   = 2'd1;
    localparam logic [1:0] MODE_QUERY    = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         entry_index;
        logic [COORD_W-1:0] entry_value;
        logic [COORD_W-1:0] query_start;
        logic [COORD_W-1:0] query_end;
        logic               last_query;
    } in_req_t;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] overlap_count;
        logic [TOTAL_W-1:0]     running_total;
    } out_req_t;

    // table write port
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [COORD_W-1:0] data;
    } tab_wr_t;

    // search launch
    typedef struct packed {
        logic               start;
        logic               strict;
        logic [COUNT_W-1:0] n;
        logic [COORD_W-1:0] key;
    } srch_cmd_t;

    // search status
    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] result;
    } srch_sts_t;

endpackage

// File: sv/ioc_search.sv
`timescale 1ns / 1ps
// One coordinate table with its own binary search sequencer.
// Depends on ioc_pkg.
module ioc_search (
    input  logic               clk,
    input  logic               rst_n,
    input  ioc_pkg::tab_wr_t   wr,
    input  ioc_pkg::srch_cmd_t cmd,
    output ioc_pkg::srch_sts_t sts
);

    localparam logic [1:0] SS_IDLE  = 2'd0;
    localparam logic [1:0] SS_ISSUE = 2'd1;
    localparam logic [1:0] SS_CMP   = 2'd2;

    logic [ioc_pkg::COORD_W-1:0] mem [ioc_pkg::MAX_ENTRIES];
    logic [ioc_pkg::COORD_W-1:0] rd_data_reg;

    logic [1:0]                  state_reg, state_next;
    logic [ioc_pkg::COUNT_W-1:0] lo_reg, lo_next;
    logic [ioc_pkg::COUNT_W-1:0] hi_reg, hi_next;
    logic [ioc_pkg::COORD_W-1:0] key_reg, key_next;
    logic                        strict_reg, strict_next;
    logic [ioc_pkg::COUNT_W-1:0] mid;
    logic [ioc_pkg::COUNT_W-1:0] span;
    logic                        go_right;

    // midpoint without overflow
    assign span = hi_reg - lo_reg;
    assign mid  = lo_reg + (span >> 1);

    // table storage with registered read at the probe address
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[mid[ioc_pkg::ADDR_W-1:0]];
    end

    // shared compare: strict for the lower search
    assign go_right = strict_reg ? (rd_data_reg < key_reg) : (rd_data_reg <= key_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        key_next    = key_reg;
        strict_next = strict_reg;
        case (state_reg)
            SS_IDLE:
            begin
                if (cmd.start)
                begin
                    lo_next     = '0;
                    hi_next     = cmd.n;
                    key_next    = cmd.key;
                    strict_next = cmd.strict;
                    state_next  = SS_ISSUE;
                end
            end
            SS_ISSUE:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = SS_CMP;
                end
                else
                begin
                    state_next = SS_IDLE;
                end
            end
            SS_CMP:
            begin
                if (go_right)
                begin
                    lo_next = mid + ioc_pkg::COUNT_W'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = SS_ISSUE;
            end
            default:
            begin
                state_next = SS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SS_IDLE;
            lo_reg     <= '0;
            hi_reg     <= '0;
            strict_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            strict_reg <= strict_next;
        end
    end

    // search key needs no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign sts.busy   = (state_reg != SS_IDLE);
    assign sts.result = lo_reg;

endmodule

// File: sv/interval_overlap_counter_core.sv
`timescale 1ns / 1ps
// Top level of the interval overlap counter: request sequencer, accumulator, output register.
// Depends on ioc_pkg and ioc_search.
//
// Usage:
//   in_valid/in_ready/in_data carry requests. Mode MODE_WR_START or MODE_WR_END
//   writes one table entry in the accepting cycle and gives no result. Mode
//   MODE_QUERY launches two binary searches, one over the start table and one
//   over the end table, running side by side, each with its own memory.
//   Mode 3 is dropped. cfg_valid/cfg_data set entry_count; cfg_ready is
//   always high and writes are expected only while the block is idle.
//   For a query, each probe is a registered memory read, then a compare, and a
//   search over n entries makes at most ceil(log2(n+1)) probes. When both
//   searches are idle, the sequencer moves to S_DONE and loads the output
//   register once it is free, which raises out_valid. Table writes can follow
//   back to back, one per cycle. in_ready is low from a query's accept until
//   its result enters the output register, so no new request is taken while
//   a query is in flight.
//   A finished query waits in the sequencer while the output register is held
//   by a stalled receiver, with in_ready low; earlier results are never lost.
//   Reset clears entry_count, the running total and all control state; the
//   table contents are undefined until written.
module interval_overlap_counter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ioc_pkg::in_req_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ioc_pkg::out_req_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ioc_pkg::CFG_W-1:0]     cfg_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [ioc_pkg::CFG_W-1:0]   entry_count_reg;
    logic [ioc_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                        last_reg, last_next;
    logic                        out_valid_reg, out_valid_next;
    ioc_pkg::out_req_t           out_data_reg, out_data_next;

    logic                        in_acc;
    logic [ioc_pkg::COUNT_W-1:0] n_eff;
    logic [ioc_pkg::COUNT_W-1:0] count;
    logic [ioc_pkg::TOTAL_W-1:0] sum;

    ioc_pkg::tab_wr_t   start_wr, end_wr;
    ioc_pkg::srch_cmd_t start_cmd, end_cmd;
    ioc_pkg::srch_sts_t start_sts, end_sts;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // effective count, saturated at table depth
    always_comb
    begin
        if (ioc_pkg::COUNT_W'(entry_count_reg) > ioc_pkg::COUNT_W'(ioc_pkg::MAX_ENTRIES))
        begin
            n_eff = ioc_pkg::COUNT_W'(ioc_pkg::MAX_ENTRIES);
        end
        else
        begin
            n_eff = ioc_pkg::COUNT_W'(entry_count_reg);
        end
    end

    // table writes
    assign start_wr.en   = in_acc && (in_data.mode == ioc_pkg::MODE_WR_START);
    assign start_wr.addr = in_data.entry_index[ioc_pkg::ADDR_W-1:0];
    assign start_wr.data = in_data.entry_value;
    assign end_wr.en     = in_acc && (in_data.mode == ioc_pkg::MODE_WR_END);
    assign end_wr.addr   = in_data.entry_index[ioc_pkg::ADDR_W-1:0];
    assign end_wr.data   = in_data.entry_value;

    // search launch
    assign start_cmd.start  = in_acc && (in_data.mode == ioc_pkg::MODE_QUERY);
    assign start_cmd.strict = 1'b0;
    assign start_cmd.n      = n_eff;
    assign start_cmd.key    = in_data.query_end;
    assign end_cmd.start    = start_cmd.start;
    assign end_cmd.strict   = 1'b1;
    assign end_cmd.n        = n_eff;
    assign end_cmd.key      = in_data.query_start;

    ioc_search u_start_search (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (start_wr),
        .cmd   (start_cmd),
        .sts   (start_sts)
    );

    ioc_search u_end_search (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (end_wr),
        .cmd   (end_cmd),
        .sts   (end_sts)
    );

    // overlap count clamped at zero, and new total
    assign count = (start_sts.result > end_sts.result) ?
                   (start_sts.result - end_sts.result) : '0;
    assign sum   = total_reg + ioc_pkg::TOTAL_W'(count);

    // sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (start_cmd.start)
                begin
                    last_next  = in_data.last_query;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (!start_sts.busy && !end_sts.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.overlap_count = ioc_pkg::OUT_COUNT_W'(count);
                    out_data_next.running_total = sum;
                    total_next                  = last_reg ? '0 : sum;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: tb/sv/overlap_checker.sv
`timescale 1ns / 1ps
// Watching checker for the interval overlap counter: mirrors both coordinate tables,
// predicts each query result and compares it with what the block returns.
// Depends on ioc_pkg.
module overlap_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  ioc_pkg::in_req_t          in_data,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  ioc_pkg::out_req_t         out_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [ioc_pkg::CFG_W-1:0] cfg_data,
    output int                        mismatch_count,
    output int                        outstanding,
    output int                        queries_checked
);

    logic [ioc_pkg::COORD_W-1:0] start_coords [ioc_pkg::MAX_ENTRIES];
    logic [ioc_pkg::COORD_W-1:0] end_coords   [ioc_pkg::MAX_ENTRIES];
    logic [ioc_pkg::TOTAL_W-1:0] total_sum;
    logic [ioc_pkg::CFG_W-1:0]   interval_count;
    ioc_pkg::out_req_t           expected_results [$];

    // number of leading start coordinates at or below the key
    function automatic int unsigned starts_upto(input logic [ioc_pkg::COORD_W-1:0] key,
                                                input int unsigned n);
        int unsigned lo, hi, mid;
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (start_coords[mid[ioc_pkg::ADDR_W-1:0]] <= key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // number of leading end coordinates strictly below the key
    function automatic int unsigned ends_before(input logic [ioc_pkg::COORD_W-1:0] key,
                                                input int unsigned n);
        int unsigned lo, hi, mid;
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (end_coords[mid[ioc_pkg::ADDR_W-1:0]] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // sample every channel on the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        ioc_pkg::out_req_t got;
        ioc_pkg::out_req_t want;
        int unsigned       n;
        int unsigned       upper;
        int unsigned       lower;
        int unsigned       overlaps;
        if (!rst_n)
        begin
            total_sum       = '0;
            interval_count  = '0;
            expected_results.delete();
            mismatch_count  = 0;
            queries_checked = 0;
            outstanding     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                interval_count = cfg_data;

            // compare a returned result with the oldest prediction
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: overlap_count %0d running_total %0d",
                                 got.overlap_count, got.running_total);
                end
                else
                begin
                    want = expected_results.pop_front();
                    queries_checked++;
                    if (got.overlap_count !== want.overlap_count ||
                        got.running_total !== want.running_total)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch on result %0d: overlap_count expected %0d ",
                                      "got %0d, running_total expected %0d got %0d"},
                                     queries_checked, want.overlap_count, got.overlap_count,
                                     want.running_total, got.running_total);
                    end
                end
            end

            // apply an accepted request to the mirrored state
            if (in_valid && in_ready)
            begin
                case (in_data.mode)
                    ioc_pkg::MODE_WR_START:
                        start_coords[in_data.entry_index] = in_data.entry_value;
                    ioc_pkg::MODE_WR_END:
                        end_coords[in_data.entry_index] = in_data.entry_value;
                    ioc_pkg::MODE_QUERY:
                    begin
                        n = (interval_count > ioc_pkg::CFG_W'(ioc_pkg::MAX_ENTRIES)) ?
                            ioc_pkg::MAX_ENTRIES : interval_count;
                        upper    = starts_upto(in_data.query_end, n);
                        lower    = ends_before(in_data.query_start, n);
                        overlaps = (upper > lower) ? upper - lower : 0;
                        total_sum = total_sum + overlaps;
                        want.overlap_count = overlaps[ioc_pkg::OUT_COUNT_W-1:0];
                        want.running_total = total_sum;
                        expected_results.push_back(want);
                        if (in_data.last_query)
                            total_sum = '0;
                    end
                    default: ;
                endcase
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the interval overlap counter testbench: clock, reset, request stimulus and verdict.
// Depends on ioc_pkg, interval_overlap_counter_core and overlap_checker.
module testbench;

    localparam logic [1:0]      MODE_UNUSED   = 2'd3;
    localparam int              CYCLE_LIMIT   = 600000;
    localparam int              SETTLE_CYCLES = 40;
    localparam int              RANDOM_ITEMS  = 380;
    localparam longint unsigned COORD_TOP     = 64'hFFFF_FFFF;
    localparam logic [31:0]     PATH_VALUE    = 32'h8000_0000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    ioc_pkg::in_req_t            in_data;
    logic                        out_valid;
    logic                        out_ready;
    ioc_pkg::out_req_t           out_data;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [ioc_pkg::CFG_W-1:0]   cfg_data;

    int                 mismatch_count;
    int                 outstanding;
    int                 queries_checked;
    int                 cycles;
    int                 random_items;
    int                 table_writes;
    int                 phases;
    bit                 idle_off;
    longint unsigned    set_lo;
    longint unsigned    set_hi;

    interval_overlap_counter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    overlap_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .queries_checked (queries_checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
    end

    // receiver side, stalls at random unless idling is off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = idle_off ? 1'b1 : ($urandom_range(99) >= 33);
        end
    end

    // request with random filler in the fields the mode ignores
    function automatic ioc_pkg::in_req_t filler_req(input logic [1:0] mode);
        ioc_pkg::in_req_t r;
        r.mode        = mode;
        r.entry_index = 10'($urandom);
        r.entry_value = $urandom;
        r.query_start = $urandom;
        r.query_end   = $urandom;
        r.last_query  = 1'($urandom);
        return r;
    endfunction

    // present one request and hold it until accepted
    task automatic send_req(input ioc_pkg::in_req_t r);
        @(negedge clk);
        while (!idle_off && $urandom_range(99) < 33)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = r;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_coord(input logic [1:0] mode, input int idx,
                               input logic [ioc_pkg::COORD_W-1:0] value);
        ioc_pkg::in_req_t r;
        r = filler_req(mode);
        r.entry_index = 10'(idx);
        r.entry_value = value;
        send_req(r);
        table_writes++;
    endtask

    task automatic send_query(input logic [ioc_pkg::COORD_W-1:0] qs,
                              input logic [ioc_pkg::COORD_W-1:0] qe,
                              input bit last);
        ioc_pkg::in_req_t r;
        r = filler_req(ioc_pkg::MODE_QUERY);
        r.query_start = qs;
        r.query_end   = qe;
        r.last_query  = last;
        send_req(r);
    endtask

    // stop sending, wait for every result, then let the block settle
    task automatic hold_off();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_count(input int value);
        hold_off();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = ioc_pkg::CFG_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ascending reference intervals from entry 0, ends never below their starts
    task automatic load_intervals(input int count, input longint unsigned base,
                                  input int unsigned step_max, input int unsigned len_max);
        longint unsigned s;
        longint unsigned e;
        longint unsigned reach;
        s = base;
        e = base;
        for (int i = 0; i < count; i++)
        begin
            s = s + 64'($urandom_range(step_max, 0));
            if (s > COORD_TOP)
                s = COORD_TOP;
            reach = s + 64'($urandom_range(len_max, 0));
            if (reach > e)
                e = reach;
            if (e > COORD_TOP)
                e = COORD_TOP;
            write_coord(ioc_pkg::MODE_WR_START, i, s[ioc_pkg::COORD_W-1:0]);
            write_coord(ioc_pkg::MODE_WR_END, i, e[ioc_pkg::COORD_W-1:0]);
        end
        set_lo = base;
        set_hi = e;
    endtask

    // one value at every probe of the all-right and all-left paths at full depth,
    // so that any full-depth search stays on written entries
    task automatic load_probe_paths(input logic [ioc_pkg::COORD_W-1:0] value);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = ioc_pkg::MAX_ENTRIES;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            write_coord(ioc_pkg::MODE_WR_START, mid, value);
            write_coord(ioc_pkg::MODE_WR_END, mid, value);
            lo = mid + 1;
        end
        lo = 0;
        hi = ioc_pkg::MAX_ENTRIES;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            write_coord(ioc_pkg::MODE_WR_START, mid, value);
            write_coord(ioc_pkg::MODE_WR_END, mid, value);
            hi = mid;
        end
    endtask

    // query mostly within the loaded span, some reversed, random or at the extremes
    task automatic random_query();
        longint unsigned span;
        longint unsigned a;
        longint unsigned b;
        logic [ioc_pkg::COORD_W-1:0] qs;
        logic [ioc_pkg::COORD_W-1:0] qe;
        int pick;
        span = set_hi - set_lo + 1;
        a = set_lo + 64'($urandom) % span;
        b = a + 1 + 64'($urandom) % (span / 4 + 1);
        if (b > COORD_TOP)
            b = COORD_TOP;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            qs = a[ioc_pkg::COORD_W-1:0];
            qe = b[ioc_pkg::COORD_W-1:0];
        end
        else if (pick < 65)
        begin
            qs = b[ioc_pkg::COORD_W-1:0];
            qe = a[ioc_pkg::COORD_W-1:0];
        end
        else if (pick < 80)
        begin
            qs = $urandom;
            qe = $urandom;
        end
        else if (pick < 90)
        begin
            qs = (pick % 2 == 0) ? set_lo[ioc_pkg::COORD_W-1:0] : set_hi[ioc_pkg::COORD_W-1:0];
            qe = qs;
        end
        else
        begin
            qs = ($urandom_range(1) == 0) ? '0 : '1;
            qe = ($urandom_range(1) == 0) ? '0 : '1;
        end
        send_query(qs, qe, $urandom_range(7) == 0);
    endtask

    // stimulus
    initial
    begin
        int n;
        int pick;
        longint unsigned base;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        idle_off     = 1'b0;
        random_items = 0;
        table_writes = 0;
        phases       = 0;
        set_lo       = 0;
        set_hi       = COORD_TOP;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty set straight after reset, plus an unused-mode request with random filler
        send_query('0, '1, 1'b0);
        send_req(filler_req(MODE_UNUSED));
        send_query('1, '0, 1'b1);

        // small hand-made set: duplicate starts, extremes, reversed query
        set_entry_count(4);
        write_coord(ioc_pkg::MODE_WR_START, 0, 32'd0);
        write_coord(ioc_pkg::MODE_WR_START, 1, 32'd10);
        write_coord(ioc_pkg::MODE_WR_START, 2, 32'd10);
        write_coord(ioc_pkg::MODE_WR_START, 3, 32'd20);
        write_coord(ioc_pkg::MODE_WR_END, 0, 32'd5);
        write_coord(ioc_pkg::MODE_WR_END, 1, 32'd15);
        write_coord(ioc_pkg::MODE_WR_END, 2, 32'd30);
        write_coord(ioc_pkg::MODE_WR_END, 3, '1);
        send_query(32'd0, 32'd0, 1'b0);
        send_query(32'd10, 32'd10, 1'b0);
        send_query(32'd16, 32'd19, 1'b0);
        send_query(32'd30, 32'd5, 1'b0);
        send_query('1, '1, 1'b0);
        send_query(32'd0, '1, 1'b1);
        // out-of-order start table
        write_coord(ioc_pkg::MODE_WR_START, 1, '1);
        send_query(32'd10, 32'd10, 1'b1);

        // full depth, count saturated above depth, single entry
        load_probe_paths(PATH_VALUE);
        set_entry_count(ioc_pkg::MAX_ENTRIES);
        send_query('0, '1, 1'b0);
        send_query(PATH_VALUE, PATH_VALUE, 1'b0);
        send_query(PATH_VALUE + 32'd1, PATH_VALUE - 32'd1, 1'b1);
        set_entry_count(2047);
        send_query('0, '1, 1'b0);
        send_query('1, '1, 1'b1);
        set_entry_count(ioc_pkg::MAX_ENTRIES + 1);
        send_query(PATH_VALUE, '1, 1'b1);
        set_entry_count(1);
        send_query('0, '0, 1'b1);

        // random phases, each with its own entry count and freshly loaded prefix
        while (random_items < RANDOM_ITEMS)
        begin
            phases++;
            pick = $urandom_range(99);
            if (pick < 70)
                n = $urandom_range(24, 1);
            else if (pick < 80)
                n = 0;
            else
                n = $urandom_range(32, 25);
            set_entry_count(n);
            idle_off = (phases == 3);

            case ($urandom_range(2))
                0:       base = 0;
                1:       base = 64'($urandom) >> 1;
                default: base = COORD_TOP - 64'($urandom_range(65535, 0));
            endcase
            load_intervals(n, base, 32'd1 << $urandom_range(26, 1),
                           32'd1 << $urandom_range(26, 1));
            random_items += 2 * n;

            repeat ($urandom_range(50, 20))
            begin
                pick = $urandom_range(99);
                if (pick < 84)
                    random_query();
                else if (pick < 92)
                    write_coord(($urandom_range(1) == 0) ? ioc_pkg::MODE_WR_START
                                                         : ioc_pkg::MODE_WR_END,
                                $urandom_range(ioc_pkg::MAX_ENTRIES - 1), $urandom);
                else
                    send_req(filler_req(MODE_UNUSED));
                random_items++;
            end
            idle_off = 1'b0;
        end

        hold_off();
        $display("covered %0d random phases on small sets plus full-depth and saturated counts",
                 phases);
        $display("%0d table writes, %0d query results checked, %0d mismatches, %0d outstanding",
                 table_writes, queries_checked, mismatch_count, outstanding);
        if (mismatch_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
